// ===== rtl/core/lrfm_pkg.sv =====
// Shared types and constants of the line-range first-match replace unit.
`default_nettype none

package lrfm_pkg;

    // Default geometry
    localparam int unsigned LINE_CHUNK_DEF  = 99;
    localparam int unsigned PATTERN_MAX_DEF = 8;
    localparam int unsigned REPLACE_MAX_DEF = 8;

    // Result queue depth, a power of two
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned LINE_W     = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [7:0]        BYTE_NEWLINE = 8'h0A;
    localparam logic [LINE_W-1:0] LINE_MAX     = 16'hFFFF;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_LINE  = 3'd0,
        REG_LAST_LINE   = 3'd1,
        REG_PATTERN     = 3'd2,
        REG_PATTERN_LEN = 3'd3,
        REG_REPLACE     = 3'd4,
        REG_REPLACE_LEN = 3'd5
    } cfg_reg_t;

    // Per-item emission flags handed from matcher to result queue
    typedef struct packed {
        logic pre_rep;   // replacement before the held bytes
        logic post_rep;  // replacement after the released bytes
        logic last;      // item closes the text
    } lrfm_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lrfm_hold_cell.sv =====
// One hold-buffer cell: a held byte and its compares against every pattern byte.
`default_nettype none

module lrfm_hold_cell #(
    parameter int unsigned PATTERN_MAX = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     load,
    input  wire logic [7:0]               d_in,
    input  wire logic [8*PATTERN_MAX-1:0] pat,
    output logic      [7:0]               q,
    output logic      [PATTERN_MAX-1:0]   eq
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= d_in;
        end
    end

    always_comb begin
        for (int d = 0; d < PATTERN_MAX; d++) begin
            eq[d] = (byte_reg == pat[8*d +: 8]);
        end
    end

    assign q = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lrfm_matcher.sv =====
// Line tracking and first-match search over a row of hold cells.
`default_nettype none

module lrfm_matcher #(
    parameter int unsigned LINE_CHUNK  = 99,
    parameter int unsigned PATTERN_MAX = 8,
    parameter int unsigned REPLACE_MAX = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                accept,
    input  wire logic [7:0]                          in_byte,
    input  wire logic                                in_last,
    input  wire logic [lrfm_pkg::LINE_W-1:0]         first_line,
    input  wire logic [lrfm_pkg::LINE_W-1:0]         last_line,
    input  wire logic [8*PATTERN_MAX-1:0]            pat,
    input  wire logic [$clog2(PATTERN_MAX+1)-1:0]    plen,
    input  wire logic [$clog2(REPLACE_MAX+1)-1:0]    rlen,
    output logic                                     push,
    output lrfm_pkg::lrfm_ctl_t                      ctl,
    output logic      [$clog2(PATTERN_MAX+1)-1:0]    nbytes,
    output logic      [8*PATTERN_MAX-1:0]            bytes
);

    import lrfm_pkg::*;

    localparam int unsigned P  = PATTERN_MAX;
    localparam int unsigned NW = $clog2(PATTERN_MAX + 1);
    localparam int unsigned CW = $clog2(LINE_CHUNK);

    logic [LINE_W-1:0] line_reg;
    logic [CW-1:0]     chunk_reg;
    logic              replaced_reg;
    logic [NW-1:0]     count_reg;

    logic [7:0]   hold_q  [P];
    logic [P-1:0] cell_eq [P];
    logic [7:0]   cell_d  [P];
    logic [7:0]   c       [P];
    logic [P-1:0] b_eq;
    logic [P-1:0] ok;
    logic [NW-1:0] n;
    logic [NW-1:0] s_sel;
    logic          active;
    logic          search;
    logic          pre_rep;
    logic          hit;
    logic          chunk_end;
    logic          keep;

    // Combined buffer: held bytes followed by the incoming byte
    assign n = count_reg + NW'(1);

    always_comb begin
        for (int j = 0; j < P; j++) begin
            c[j] = (NW'(j) < count_reg) ? hold_q[j] : in_byte;
            bytes[8*j +: 8] = c[j];
        end
        for (int d = 0; d < P; d++) begin
            b_eq[d] = (in_byte == pat[8*d +: 8]);
        end
    end

    // Shift s survives if the tail from s is a pattern prefix no longer than plen
    always_comb begin
        logic eq_bit;
        eq_bit = 1'b0;
        for (int s = 0; s < P; s++) begin
            ok[s] = (NW'(s) < n) && ((n - NW'(s)) <= plen);
            for (int j = s; j < P; j++) begin
                if (NW'(j) < n) begin
                    eq_bit = (NW'(j) < count_reg) ? cell_eq[j][j-s] : b_eq[j-s];
                    if (!eq_bit) begin
                        ok[s] = 1'b0;
                    end
                end
            end
        end
        s_sel = n;
        for (int s = P - 1; s >= 0; s--) begin
            if (ok[s]) begin
                s_sel = NW'(s);
            end
        end
    end

    assign active    = !replaced_reg && (line_reg >= first_line) && (line_reg <= last_line);
    assign search    = active && (plen != '0);
    assign pre_rep   = active && (plen == '0) && (chunk_reg == '0);
    assign hit       = search && ((n - s_sel) == plen);
    assign chunk_end = (in_byte == BYTE_NEWLINE) || (chunk_reg == CW'(LINE_CHUNK - 1)) || in_last;
    assign keep      = search && !hit && !chunk_end;

    always_comb begin
        if (search && (hit || !chunk_end)) begin
            nbytes = s_sel;
        end else begin
            nbytes = n;
        end
    end

    assign ctl.pre_rep  = pre_rep;
    assign ctl.post_rep = hit;
    assign ctl.last     = in_last;
    assign push = accept && ((nbytes != '0) || ((pre_rep || hit) && (rlen != '0)));

    // Row of cells; each reloads from the buffer byte s_sel places up the row
    for (genvar j = 0; j < P; j++) begin : g_cell
        always_comb begin
            cell_d[j] = c[j];
            for (int k = 1; k < P - j; k++) begin
                if (s_sel == NW'(k)) begin
                    cell_d[j] = c[j+k];
                end
            end
        end

        lrfm_hold_cell #(
            .PATTERN_MAX(P)
        ) u_cell (
            .aclk (aclk),
            .load (accept && keep),
            .d_in (cell_d[j]),
            .pat  (pat),
            .q    (hold_q[j]),
            .eq   (cell_eq[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg     <= LINE_W'(1);
            chunk_reg    <= '0;
            replaced_reg <= 1'b0;
            count_reg    <= '0;
        end else if (accept) begin
            if (in_last) begin
                line_reg <= LINE_W'(1);
            end else if (chunk_end && (line_reg != LINE_MAX)) begin
                line_reg <= line_reg + LINE_W'(1);
            end
            chunk_reg    <= chunk_end ? '0 : chunk_reg + CW'(1);
            replaced_reg <= chunk_end ? 1'b0 : (replaced_reg || pre_rep || hit);
            count_reg    <= keep ? (n - s_sel) : '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lrfm_out_queue.sv =====
// Result queue: holds per-item emission records and serializes them to bytes.
`default_nettype none

module lrfm_out_queue #(
    parameter int unsigned PATTERN_MAX = 8,
    parameter int unsigned REPLACE_MAX = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                push,
    input  wire lrfm_pkg::lrfm_ctl_t                 ctl,
    input  wire logic [$clog2(PATTERN_MAX+1)-1:0]    nbytes,
    input  wire logic [8*PATTERN_MAX-1:0]            bytes,
    input  wire logic [lrfm_pkg::CFG_DATA_W-1:0]     rep_bytes,
    input  wire logic [$clog2(REPLACE_MAX+1)-1:0]    rlen,
    output logic                                     ready,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [7:0]                          m_tdata,
    output logic                                     m_tlast
);

    import lrfm_pkg::*;

    localparam int unsigned P  = PATTERN_MAX;
    localparam int unsigned R  = REPLACE_MAX;
    localparam int unsigned NW = $clog2(PATTERN_MAX + 1);
    localparam int unsigned PW = $clog2(PATTERN_MAX + REPLACE_MAX);
    localparam int unsigned TW = PW + 1;
    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    lrfm_ctl_t          ctl_mem   [QUEUE_DEPTH];
    logic [NW-1:0]      n_mem     [QUEUE_DEPTH];
    logic [8*P-1:0]     bytes_mem [QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic [PW-1:0] pos_reg;

    lrfm_ctl_t      h_ctl;
    logic [NW-1:0]  h_n;
    logic [8*P-1:0] h_bytes;
    logic [TW-1:0]  total;
    logic [TW-1:0]  pos_x;
    logic [TW-1:0]  idx;
    logic [TW-1:0]  rep_idx;
    logic           use_rep;
    logic           is_final;
    logic           pop;

    assign h_ctl   = ctl_mem[rd_ptr_reg];
    assign h_n     = n_mem[rd_ptr_reg];
    assign h_bytes = bytes_mem[rd_ptr_reg];

    assign pos_x = TW'(pos_reg);
    assign total = TW'(h_n) + ((h_ctl.pre_rep || h_ctl.post_rep) ? TW'(rlen) : '0);
    assign is_final = ((pos_x + TW'(1)) == total);

    assign m_tvalid = (count_reg != '0);
    assign ready    = (count_reg != (AW+1)'(QUEUE_DEPTH));
    assign pop      = m_tvalid && m_tready && is_final;
    assign m_tlast  = h_ctl.last && is_final;

    // Pick the byte for the current position of the head record
    always_comb begin
        use_rep = 1'b0;
        rep_idx = pos_x;
        idx     = h_ctl.pre_rep ? (pos_x - TW'(rlen)) : pos_x;
        if (h_ctl.pre_rep && (pos_x < TW'(rlen))) begin
            use_rep = 1'b1;
        end else if (idx >= TW'(h_n)) begin
            use_rep = 1'b1;
            rep_idx = pos_x - TW'(h_n);
        end
        m_tdata = h_bytes[7:0];
        if (use_rep) begin
            m_tdata = rep_bytes[7:0];
            for (int i = 0; i < R; i++) begin
                if (rep_idx == TW'(i)) begin
                    m_tdata = rep_bytes[8*i +: 8];
                end
            end
        end else begin
            for (int j = 0; j < P; j++) begin
                if (idx == TW'(j)) begin
                    m_tdata = h_bytes[8*j +: 8];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ctl_mem[wr_ptr_reg]   <= ctl;
            n_mem[wr_ptr_reg]     <= nbytes;
            bytes_mem[wr_ptr_reg] <= bytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
            if (m_tvalid && m_tready) begin
                pos_reg <= is_final ? '0 : pos_reg + PW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/line_range_first_match_replace_unit.sv =====
// Top level of the line-range first-match replace unit.
//
// Usage: text bytes enter on the s_ channel, one per transfer, with s_tlast on
// the final byte of a text. In lines whose number lies in [first_line,
// last_line] the leftmost occurrence of the pattern is replaced; a line ends
// at a newline, after LINE_CHUNK bytes, or at s_tlast. Bytes of a partial
// match are held inside the block until the match completes or fails, so the
// result stream lags the input by up to pattern length minus one bytes.
// Results leave on the m_ channel, one byte per transfer, m_tlast on the last
// result byte of the text.
// Results that a byte releases are registered into the result queue as it is taken.
// Input: one byte per cycle while the result queue has room; the m_ side moves one
// byte per cycle while m_tready is high, one transfer per result byte. A
// four-entry result queue between the matcher and the output keeps input
// flowing while results wait; s_tready drops only when that queue is full.
// When the receiver stalls, hold m_tdata/m_tlast and fill the queue, then stall
// the sender. Reset sets line count 1, clears held bytes and queue, and loads
// first_line 1 with all other registers 0. Write registers only while idle.
`default_nettype none

module line_range_first_match_replace_unit #(
    parameter int unsigned LINE_CHUNK  = lrfm_pkg::LINE_CHUNK_DEF,
    parameter int unsigned PATTERN_MAX = lrfm_pkg::PATTERN_MAX_DEF,
    parameter int unsigned REPLACE_MAX = lrfm_pkg::REPLACE_MAX_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] in_byte
    input  wire logic                                s_tlast,   // in_last
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [7:0]                          m_tdata,   // [7:0] out_byte
    output logic                                     m_tlast,   // out_last
    // Register write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [lrfm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [lrfm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import lrfm_pkg::*;

    localparam int unsigned NW  = $clog2(PATTERN_MAX + 1);
    localparam int unsigned RLW = $clog2(REPLACE_MAX + 1);

    // Configuration registers
    logic [LINE_W-1:0]     first_line_reg;
    logic [LINE_W-1:0]     last_line_reg;
    logic [CFG_DATA_W-1:0] pattern_reg;
    logic [3:0]            pattern_len_reg;
    logic [CFG_DATA_W-1:0] replace_reg;
    logic [3:0]            replace_len_reg;

    logic [NW-1:0]              plen_eff;
    logic [RLW-1:0]             rlen_eff;
    logic                       accept;
    logic                       push;
    lrfm_ctl_t                  ctl;
    logic [NW-1:0]              nbytes;
    logic [8*PATTERN_MAX-1:0]   bytes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_line_reg  <= LINE_W'(1);
            last_line_reg   <= '0;
            pattern_reg     <= '0;
            pattern_len_reg <= '0;
            replace_reg     <= '0;
            replace_len_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FIRST_LINE:  first_line_reg  <= cfg_wdata[LINE_W-1:0];
                REG_LAST_LINE:   last_line_reg   <= cfg_wdata[LINE_W-1:0];
                REG_PATTERN:     pattern_reg     <= cfg_wdata;
                REG_PATTERN_LEN: pattern_len_reg <= cfg_wdata[3:0];
                REG_REPLACE:     replace_reg     <= cfg_wdata;
                REG_REPLACE_LEN: replace_len_reg <= cfg_wdata[3:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Clamp oversized lengths to the hardware maxima
    assign plen_eff = (pattern_len_reg > 4'(PATTERN_MAX)) ? NW'(PATTERN_MAX)
                                                          : NW'(pattern_len_reg);
    assign rlen_eff = (replace_len_reg > 4'(REPLACE_MAX)) ? RLW'(REPLACE_MAX)
                                                          : RLW'(replace_len_reg);

    assign accept = s_tvalid && s_tready;

    lrfm_matcher #(
        .LINE_CHUNK  (LINE_CHUNK),
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_matcher (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .first_line (first_line_reg),
        .last_line  (last_line_reg),
        .pat        (pattern_reg[8*PATTERN_MAX-1:0]),
        .plen       (plen_eff),
        .rlen       (rlen_eff),
        .push       (push),
        .ctl        (ctl),
        .nbytes     (nbytes),
        .bytes      (bytes)
    );

    // Items that release nothing never enter the queue
    lrfm_out_queue #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .ctl       (ctl),
        .nbytes    (nbytes),
        .bytes     (bytes),
        .rep_bytes (replace_reg),
        .rlen      (rlen_eff),
        .ready     (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
